@@ rtl/core/k_way_merge_min_heap_assert.svh @@
// Assertion macros for the k-way merge block.
// In synthesis the macros expand to nothing.
`ifndef K_WAY_MERGE_MIN_HEAP_ASSERT_SVH
`define K_WAY_MERGE_MIN_HEAP_ASSERT_SVH
`ifndef SYNTHESIS
`define KWM_ASSERT_NOW(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define KWM_ASSERT_NOW(label, clk, rst_n, prop, msg)
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/kwm_pkg.sv @@
`timescale 1ns / 1ps
package kwm_pkg;

    localparam int ValueW  = 16;
    localparam int SourceW = 6;
    localparam int CfgW    = 7;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REPLACE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ValueW-1:0] value;
        logic              exhausted;
    } t_in_word;

    typedef struct packed {
        logic [ValueW-1:0]  min_value;
        logic [SourceW-1:0] min_source;
        logic               all_exhausted;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD_RD,
        S_BUILD_CUR,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EMIT
    } t_state;

endpackage

@@ rtl/core/kwm_heap_ram.sv @@
`timescale 1ns / 1ps
module kwm_heap_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 23
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

@@ rtl/core/kwm_sifter.sv @@
`timescale 1ns / 1ps
module kwm_sifter #(
    parameter int MAX_LISTS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [$clog2(MAX_LISTS+1)-1:0]           i_heap_n,
    input  logic                                     i_in_acc,
    input  kwm_pkg::t_in_word                        i_in,
    output logic                                     o_busy,
    output logic                                     o_res_valid,
    output kwm_pkg::t_out_word                       o_res,
    input  logic                                     i_res_free,
    output logic                                     o_we,
    output logic [$clog2(MAX_LISTS)-1:0]             o_waddr,
    output logic [$clog2(MAX_LISTS)+VALUE_BITS:0]    o_wdata,
    output logic [$clog2(MAX_LISTS)-1:0]             o_raddr_a,
    output logic [$clog2(MAX_LISTS)-1:0]             o_raddr_b,
    input  logic [$clog2(MAX_LISTS)+VALUE_BITS:0]    i_rdata_a,
    input  logic [$clog2(MAX_LISTS)+VALUE_BITS:0]    i_rdata_b
);
    import kwm_pkg::*;

    localparam int IdxBits = $clog2(MAX_LISTS);
    localparam int CntBits = $clog2(MAX_LISTS + 1);
    localparam int ChBits  = IdxBits + 2;

    typedef struct packed {
        logic                  done;
        logic [IdxBits-1:0]    src;
        logic [VALUE_BITS-1:0] val;
    } t_entry;

    // An exhausted entry never ranks below anything; a live one ranks below
    // any exhausted entry.
    function automatic logic ranks_below(input t_entry x, input t_entry y);
        return !x.done && (y.done || (x.val < y.val));
    endfunction

    t_state r_state, n_state;
    logic [CntBits-1:0] r_loaded, n_loaded;
    logic               r_merging, n_merging;
    logic               r_building, n_building;
    logic [IdxBits-1:0] r_bi, n_bi;
    logic [IdxBits-1:0] r_pos, n_pos;
    t_entry             r_cur, n_cur;
    t_entry             r_root;

    t_entry rd_a, rd_b, wr_ent, best;
    logic [VALUE_BITS+ValueW-1:0] in_wide;
    logic [VALUE_BITS-1:0]        in_val;
    logic [CntBits-1:0]           load_base, load_idx, load_next, half_n;
    logic                         load_last;
    logic [ChBits-1:0]            left, right, n_ext;
    logic                         l_ok, r_ok, moved;
    logic [ChBits-1:0]            best_idx;
    logic [VALUE_BITS+ValueW-1:0] root_wide;
    logic [IdxBits+SourceW-1:0]   src_wide;

    assign rd_a = t_entry'(i_rdata_a);
    assign rd_b = t_entry'(i_rdata_b);

    assign in_wide = {{VALUE_BITS{1'b0}}, i_in.value};
    assign in_val  = i_in.exhausted ? '0 : in_wide[VALUE_BITS-1:0];

    // A load after a finished build starts a new merge at list 0. A load past
    // a shrunken heap lands on the last entry.
    assign load_base = r_merging ? '0 : r_loaded;
    assign load_idx  = (load_base >= i_heap_n) ? i_heap_n - 1'b1 : load_base;
    assign load_next = load_idx + 1'b1;
    assign load_last = (load_next >= i_heap_n);
    assign half_n    = i_heap_n >> 1;

    assign left  = {1'b0, r_pos, 1'b1};
    assign right = left + 1'b1;
    assign n_ext = ChBits'(i_heap_n);
    assign l_ok  = left < n_ext;
    assign r_ok  = right < n_ext;

    always_comb begin
        best     = r_cur;
        best_idx = '0;
        moved    = 1'b0;
        if (l_ok && ranks_below(rd_a, r_cur)) begin
            best     = rd_a;
            best_idx = left;
            moved    = 1'b1;
        end
        if (r_ok && ranks_below(rd_b, best)) begin
            best     = rd_b;
            best_idx = right;
            moved    = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    unique case (i_in.mode)
                        MODE_LOAD: begin
                            if (load_last) begin
                                n_state = (half_n == '0) ? S_EMIT : S_BUILD_RD;
                            end
                        end
                        MODE_REPLACE: begin
                            if (r_merging) begin
                                n_state = S_SIFT_RD;
                            end
                        end
                    endcase
                end
            end
            S_BUILD_RD:  n_state = S_BUILD_CUR;
            S_BUILD_CUR: n_state = S_SIFT_RD;
            S_SIFT_RD:   n_state = S_SIFT_CMP;
            S_SIFT_CMP: begin
                if (moved) begin
                    n_state = S_SIFT_RD;
                end else if (r_building && (r_bi != '0)) begin
                    n_state = S_BUILD_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_loaded   = r_loaded;
        n_merging  = r_merging;
        n_building = r_building;
        n_bi       = r_bi;
        n_pos      = r_pos;
        n_cur      = r_cur;
        o_we       = 1'b0;
        o_waddr    = r_pos;
        wr_ent     = r_cur;
        o_raddr_a  = left[IdxBits-1:0];
        o_raddr_b  = right[IdxBits-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    unique case (i_in.mode)
                        MODE_LOAD: begin
                            o_we       = 1'b1;
                            o_waddr    = load_idx[IdxBits-1:0];
                            wr_ent     = '{done: i_in.exhausted,
                                           src:  load_idx[IdxBits-1:0],
                                           val:  in_val};
                            n_loaded   = load_next;
                            n_merging  = load_last;
                            n_building = load_last && (half_n != '0);
                            n_bi       = IdxBits'(half_n - 1'b1);
                        end
                        MODE_REPLACE: begin
                            n_cur      = '{done: i_in.exhausted, src: r_root.src,
                                           val: in_val};
                            n_pos      = '0;
                            n_building = 1'b0;
                        end
                    endcase
                end
            end
            S_BUILD_RD: begin
                o_raddr_a = r_bi;
            end
            S_BUILD_CUR: begin
                n_cur = rd_a;
                n_pos = r_bi;
            end
            S_SIFT_RD: begin
            end
            S_SIFT_CMP: begin
                o_we   = 1'b1;
                wr_ent = best;
                if (moved) begin
                    n_pos = best_idx[IdxBits-1:0];
                end else if (r_building && (r_bi != '0)) begin
                    n_bi = r_bi - 1'b1;
                end else begin
                    n_building = 1'b0;
                end
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_wdata = wr_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loaded   <= '0;
            r_merging  <= 1'b0;
            r_building <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_merging  <= n_merging;
            r_building <= n_building;
        end
    end

    // The root copy follows every write to entry 0, so it always mirrors the
    // top of the heap.
    always_ff @(posedge i_clk) begin
        r_bi  <= n_bi;
        r_pos <= n_pos;
        r_cur <= n_cur;
        if (o_we && (o_waddr == '0)) begin
            r_root <= wr_ent;
        end
    end

    assign root_wide = {{ValueW{1'b0}}, r_root.val};
    assign src_wide  = {{SourceW{1'b0}}, r_root.src};

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);

    always_comb begin
        if (r_root.done) begin
            o_res = '{min_value: '0, min_source: '0, all_exhausted: 1'b1};
        end else begin
            o_res = '{min_value:     root_wide[ValueW-1:0],
                      min_source:    src_wide[SourceW-1:0],
                      all_exhausted: 1'b0};
        end
    end

endmodule

@@ rtl/core/k_way_merge_min_heap.sv @@
`timescale 1ns / 1ps
`include "k_way_merge_min_heap_assert.svh"
// K-way merge through a binary min-heap of list heads kept in a two-read,
// one-write memory. Load words store one head per list in order; after the
// head of list num_lists-1 the heap is built bottom-up and the smallest head
// is returned with its list index. Each replace word then puts the next
// value (or an exhausted mark) of that list at the root, sifts it down and
// returns the new minimum. A load that is not the last returns nothing. A
// replace sifts the new root down L levels, at most floor(log2(num_lists)):
// every level first reads both children from the memory and then compares
// and writes back. The build after the last load runs one such sift for each
// of the num_lists/2 inner nodes, each after first fetching the node.
// A new word is taken while the previous result still waits in the output
// register. num_lists must be written only while the block is idle; the
// block itself does not enforce this. 0 acts as 1 and values above
// MAX_LISTS act as MAX_LISTS.
module k_way_merge_min_heap #(
    parameter int MAX_LISTS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [kwm_pkg::CfgW-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  kwm_pkg::t_in_word            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kwm_pkg::t_out_word           o_out
);
    import kwm_pkg::*;

    localparam int IdxBits = $clog2(MAX_LISTS);
    localparam int CntBits = $clog2(MAX_LISTS + 1);
    localparam int EntBits = 1 + IdxBits + VALUE_BITS;

    logic [CfgW-1:0]    r_num_lists;
    logic [31:0]        cfg_ext;
    logic [CntBits-1:0] heap_n;

    logic      r_out_valid;
    t_out_word r_out;

    logic               busy, in_acc, out_free;
    logic               w_res_valid;
    t_out_word          w_res;
    logic               mem_we;
    logic [IdxBits-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [EntBits-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

    // The one configuration register: the number of lists, i.e. heap size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lists <= CfgW'(1);
        end else if (i_cfg_we) begin
            r_num_lists <= i_cfg_data;
        end
    end

    // Clamp the written count into 1..MAX_LISTS.
    always_comb begin
        cfg_ext = 32'(r_num_lists);
        if (cfg_ext == 32'd0) begin
            heap_n = CntBits'(1);
        end else if (cfg_ext > 32'(MAX_LISTS)) begin
            heap_n = CntBits'(MAX_LISTS);
        end else begin
            heap_n = CntBits'(cfg_ext);
        end
    end

    // Input words are taken only while the heap logic is idle.
    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;

    kwm_heap_ram #(
        .DEPTH(MAX_LISTS),
        .WIDTH(EntBits)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    kwm_sifter #(
        .MAX_LISTS (MAX_LISTS),
        .VALUE_BITS(VALUE_BITS)
    ) u_sifter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_heap_n   (heap_n),
        .i_in_acc   (in_acc),
        .i_in       (i_in),
        .o_busy     (busy),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_free (out_free),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr_a  (mem_raddr_a),
        .o_raddr_b  (mem_raddr_b),
        .i_rdata_a  (mem_rdata_a),
        .i_rdata_b  (mem_rdata_b)
    );

    // Output register. It frees up in the same cycle its word is taken, so
    // a finished result moves in without a bubble.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && out_free) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A result that cannot move into the output register must wait unchanged.
    `KWM_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, w_res_valid && !out_free, w_res_valid && $stable(w_res), "pending result was lost or changed")
    // The output register only fills from a result offered by the heap logic.
    `KWM_ASSERT_NOW(a_out_from_res, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_res_valid), "output word appeared without a result")
    // A finished merge reports zero value and zero source.
    `KWM_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, (o_out_valid && o_out.all_exhausted) |-> (o_out.min_value == '0 && o_out.min_source == '0), "finished merge carries a nonzero value or source")

endmodule
